// ===== rtl/mhpq_pkg.sv =====
// shared types and codes for the max-heap priority queue
`default_nettype none

package mhpq_pkg;

    // operation codes carried in s_tuser
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // result status codes carried in m_tuser
    typedef enum logic [1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_EXTRACTED = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // one heap entry: priority in the upper half, payload tag in the lower half
    localparam int ENTRY_W = 32;
    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 7;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EX_LAST,
        ST_EX_WRITE,
        ST_RB_START,
        ST_SD_POS,
        ST_SD_LOAD,
        ST_SD_CMPL,
        ST_SD_CMPR,
        ST_SD_WRPOS,
        ST_SD_WRBIG,
        ST_SD_NEXT,
        ST_OUT
    } ctrl_state_t;

    // datapath commands
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_REJECT_EMPTY,
        DP_REJECT_FULL,
        DP_INS_WRITE,
        DP_EX_RD_ROOT,
        DP_EX_RD_LAST,
        DP_EX_WR_ROOT,
        DP_RB_START,
        DP_SD_RD_POS,
        DP_SD_LOAD,
        DP_SD_CMP_L,
        DP_SD_CMP_R,
        DP_SD_WR_POS,
        DP_SD_WR_BIG,
        DP_SD_NEXT,
        DP_OUT
    } dp_op_t;

    // datapath status toward the controller
    typedef struct packed {
        logic is_extract;
        logic full;
        logic empty;
        logic below_two;
        logic l_ok;
        logic r_ok;
        logic lb_ok;
        logic swap;
        logic i_zero;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mhpq_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/mhpq_ctrl.sv =====
// controller state machine sequencing insert, extract and the heap rebuild
`default_nettype none

module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_op_t        cmd
);

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd        = DP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = DP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_extract)
                begin
                    if (stat.empty)
                    begin
                        cmd        = DP_REJECT_EMPTY;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd        = DP_EX_RD_ROOT;
                        state_next = ST_EX_LAST;
                    end
                end
                else if (stat.full)
                begin
                    cmd        = DP_REJECT_FULL;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd        = DP_INS_WRITE;
                    state_next = ST_RB_START;
                end
            end
            ST_EX_LAST:
            begin
                cmd        = DP_EX_RD_LAST;
                state_next = ST_EX_WRITE;
            end
            ST_EX_WRITE:
            begin
                cmd        = DP_EX_WR_ROOT;
                state_next = ST_RB_START;
            end
            ST_RB_START:
            begin
                cmd        = DP_RB_START;
                state_next = stat.below_two ? ST_OUT : ST_SD_POS;
            end
            ST_SD_POS:
            begin
                cmd        = DP_SD_RD_POS;
                state_next = ST_SD_LOAD;
            end
            ST_SD_LOAD:
            begin
                cmd        = DP_SD_LOAD;
                state_next = stat.l_ok ? ST_SD_CMPL : ST_SD_NEXT;
            end
            ST_SD_CMPL:
            begin
                cmd        = DP_SD_CMP_L;
                state_next = stat.r_ok ? ST_SD_CMPR : ST_SD_WRPOS;
            end
            ST_SD_CMPR:
            begin
                cmd        = DP_SD_CMP_R;
                state_next = ST_SD_WRPOS;
            end
            ST_SD_WRPOS:
            begin
                if (stat.swap)
                begin
                    cmd        = DP_SD_WR_POS;
                    state_next = ST_SD_WRBIG;
                end
                else
                begin
                    state_next = ST_SD_NEXT;
                end
            end
            ST_SD_WRBIG:
            begin
                cmd        = DP_SD_WR_BIG;
                state_next = stat.lb_ok ? ST_SD_CMPL : ST_SD_NEXT;
            end
            ST_SD_NEXT:
            begin
                if (stat.i_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd        = DP_SD_NEXT;
                    state_next = ST_SD_POS;
                end
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd        = DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mhpq_dp.sv =====
// datapath: heap memory, count, sift-down registers and output register
`default_nettype none

module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_op_t               cmd,
    output dp_stat_t                  stat,
    input  wire logic                 in_op,
    input  wire logic [PRIO_W-1:0]    in_prio,
    input  wire logic [TAG_W-1:0]     in_payload,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                out_status,
    output logic [PRIO_W-1:0]         out_prio,
    output logic [TAG_W-1:0]          out_payload,
    output logic [COUNT_W-1:0]        out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    // request capture
    logic                op_reg;
    logic [PRIO_W-1:0]   in_prio_reg;
    logic [TAG_W-1:0]    in_payload_reg;

    // heap control and sift registers
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       bidx_reg, bidx_next;
    logic [ENTRY_W-1:0]  cur_reg, cur_next;
    logic [ENTRY_W-1:0]  big_reg, big_next;
    logic [ENTRY_W-1:0]  root_reg, root_next;
    status_t             res_reg, res_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [TAG_W-1:0]    out_payload_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    // memory ports
    logic                we;
    logic [AW-1:0]       waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [AW-1:0]       raddr;
    logic [ENTRY_W-1:0]  rdata;

    // index arithmetic
    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       cnt_half;
    logic [XW-1:0]       n_ext;
    logic [XW-1:0]       lx;
    logic [XW-1:0]       rx;
    logic [XW-1:0]       lbx;
    logic [CW+COUNT_W-1:0] cnt_wide;
    logic                big_lt_rd;

    mhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cnt_m1    = count_reg - 1'b1;
    assign cnt_half  = cnt_m1 >> 1;
    assign n_ext     = {{(XW-CW){1'b0}}, count_reg};
    assign lx        = {1'b0, pos_reg, 1'b1};
    assign rx        = lx + 1'b1;
    assign lbx       = {1'b0, bidx_reg, 1'b1};
    assign cnt_wide  = {{COUNT_W{1'b0}}, count_reg};
    assign big_lt_rd = $signed(big_reg[ENTRY_W-1 -: PRIO_W])
                       < $signed(rdata[ENTRY_W-1 -: PRIO_W]);

    // status toward the controller
    always_comb
    begin
        stat.is_extract = (op_reg == OP_EXTRACT);
        stat.full       = (count_reg == CW'(CAPACITY));
        stat.empty      = (count_reg == '0);
        stat.below_two  = (count_reg < CW'(2));
        stat.l_ok       = (lx < n_ext);
        stat.r_ok       = (rx < n_ext);
        stat.lb_ok      = (lbx < n_ext);
        stat.swap       = (bidx_reg != pos_reg);
        stat.i_zero     = (i_reg == '0);
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    // command decode
    always_comb
    begin
        count_next     = count_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        bidx_next      = bidx_reg;
        cur_next       = cur_reg;
        big_next       = big_reg;
        root_next      = root_reg;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = big_reg;
        raddr          = pos_reg;
        unique case (cmd)
            DP_NOP, DP_CAPTURE, DP_OUT:
            begin
            end
            DP_REJECT_EMPTY:
            begin
                res_next = STAT_EMPTY;
            end
            DP_REJECT_FULL:
            begin
                res_next = STAT_FULL;
            end
            DP_INS_WRITE:
            begin
                we         = 1'b1;
                waddr      = count_reg[AW-1:0];
                wdata      = {in_prio_reg, in_payload_reg};
                count_next = count_reg + 1'b1;
                res_next   = STAT_INSERTED;
            end
            DP_EX_RD_ROOT:
            begin
                raddr = '0;
            end
            DP_EX_RD_LAST:
            begin
                root_next = rdata;
                raddr     = cnt_m1[AW-1:0];
                res_next  = STAT_EXTRACTED;
            end
            DP_EX_WR_ROOT:
            begin
                // last entry moves to the root
                we         = 1'b1;
                waddr      = '0;
                wdata      = rdata;
                count_next = cnt_m1;
            end
            DP_RB_START:
            begin
                i_next   = cnt_half[AW-1:0];
                pos_next = cnt_half[AW-1:0];
            end
            DP_SD_RD_POS:
            begin
                raddr = pos_reg;
            end
            DP_SD_LOAD:
            begin
                cur_next  = rdata;
                big_next  = rdata;
                bidx_next = pos_reg;
                raddr     = lx[AW-1:0];
            end
            DP_SD_CMP_L:
            begin
                if (big_lt_rd)
                begin
                    big_next  = rdata;
                    bidx_next = lx[AW-1:0];
                end
                raddr = rx[AW-1:0];
            end
            DP_SD_CMP_R:
            begin
                if (big_lt_rd)
                begin
                    big_next  = rdata;
                    bidx_next = rx[AW-1:0];
                end
            end
            DP_SD_WR_POS:
            begin
                we    = 1'b1;
                waddr = pos_reg;
                wdata = big_reg;
            end
            DP_SD_WR_BIG:
            begin
                // sifted entry lands at the child, continue one level down
                we        = 1'b1;
                waddr     = bidx_reg;
                wdata     = cur_reg;
                pos_next  = bidx_reg;
                big_next  = cur_reg;
                raddr     = lbx[AW-1:0];
            end
            DP_SD_NEXT:
            begin
                i_next   = i_reg - 1'b1;
                pos_next = i_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd == DP_OUT)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd == DP_CAPTURE)
        begin
            op_reg         <= in_op;
            in_prio_reg    <= in_prio;
            in_payload_reg <= in_payload;
        end
        i_reg    <= i_next;
        pos_reg  <= pos_next;
        bidx_reg <= bidx_next;
        cur_reg  <= cur_next;
        big_reg  <= big_next;
        root_reg <= root_next;
        res_reg  <= res_next;
        if (cmd == DP_OUT)
        begin
            out_status_reg <= res_reg;
            out_count_reg  <= cnt_wide[COUNT_W-1:0];
            if (res_reg == STAT_EXTRACTED)
            begin
                out_prio_reg    <= root_reg[ENTRY_W-1 -: PRIO_W];
                out_payload_reg <= root_reg[TAG_W-1:0];
            end
            else
            begin
                out_prio_reg    <= '0;
                out_payload_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_prio    = out_prio_reg;
    assign out_payload = out_payload_reg;
    assign out_count   = out_count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_no_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == DP_INS_WRITE) |-> (count_reg != CW'(CAPACITY)))
        else $error("insert write on a full heap");
    a_no_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == DP_EX_RD_ROOT) |-> (count_reg != '0))
        else $error("extract on an empty heap");
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == DP_OUT) |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten before it was taken");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == DP_INS_WRITE) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");
`endif

endmodule

`default_nettype wire

// ===== rtl/max_heap_priority_queue.sv =====
// top level of the binary max-heap priority queue
//
// One request enters on the s_ channel: s_tuser is the operation (insert or
// extract), s_tdata carries the priority and payload tag of an insert.
// Every request yields exactly one result on the m_ channel: m_tuser is the
// status (inserted, extracted, extract on empty, insert on full dropped),
// m_tdata the extracted entry and the count held afterwards.
// Requests are handled one at a time. After each insert or extract the heap
// is rebuilt bottom-up by sift-down at every parent position, through one
// single-port-read heap memory: each position is read and compared with its
// children, and the entry moves down one level per swap until no child is
// larger; rejected requests and heaps below two entries skip the rebuild.
// s_tready is high only while no request is in work. A finished result sits
// in an output register; the next request is accepted while it waits, and
// that request's result is held back until m_tready takes the first one.
// Reset clears the count and the output valid; heap contents need no clear.
`default_nettype none

module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // priority_req [15:0], payload [31:16]
    input  wire logic [0:0]  s_tuser,   // op [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_priority [15:0], out_payload [31:16],
                                        // count [38:32], zero [39]
    output logic [1:0]       m_tuser    // status [1:0]
);

    dp_op_t             cmd;
    dp_stat_t           stat;
    logic [1:0]         out_status;
    logic [PRIO_W-1:0]  out_prio;
    logic [TAG_W-1:0]   out_payload;
    logic [COUNT_W-1:0] out_count;

    // controller
    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_tuser[0]),
        .in_prio     (s_tdata[15:0]),
        .in_payload  (s_tdata[31:16]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_prio    (out_prio),
        .out_payload (out_payload),
        .out_count   (out_count)
    );

    // result packing
    assign m_tdata = {1'b0, out_count, out_payload, out_prio};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== test/max_heap_priority_queue_tb.sv =====
// self-checking testbench for the max-heap priority queue: directed table, then random traffic
`timescale 1ns / 100ps

module max_heap_priority_queue_tb
    import mhpq_pkg::*;
();

    localparam int HEAP_DEPTH = 64;
    localparam int TABLE_LEN  = 23;
    localparam int PHASE_LEN  = 225;
    localparam int SETTLE_CYC = 600;

    // one result as seen on the master side
    typedef struct {
        status_t            status;
        logic signed [15:0] prio;
        logic [15:0]        tag;
        logic [6:0]         count;
    } heap_result_t;

    // per-request choice: typed-in result or the predictor's
    typedef struct {
        bit           typed;
        heap_result_t want;
    } pinned_result_t;

    typedef struct {
        logic               op;
        logic signed [15:0] prio;
        logic [15:0]        tag;
        bit                 typed;
        heap_result_t       want;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // predictor state: heap contents and number of entries held
    logic signed [15:0] heap_prio [HEAP_DEPTH];
    logic [15:0]        heap_tag [HEAP_DEPTH];
    int                 held = 0;

    heap_result_t   expected_q [$];
    pinned_result_t pinned_q [$];
    heap_result_t   blank_result = '{STAT_INSERTED, '0, '0, '0};
    int             error_count = 0;
    int             send_gap_pct = 0;
    int             recv_stall_pct = 0;

    // directed requests: extremes, empty and tie cases
    table_row_t req_table [TABLE_LEN] = '{
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b1, '{STAT_EMPTY, 16'sh0000, 16'h0000, 7'd0}},
        '{OP_INSERT, 16'sh7FFF, 16'hFFFF, 1'b1, '{STAT_INSERTED, 16'sh0000, 16'h0000, 7'd1}},
        '{OP_INSERT, 16'sh8000, 16'h0000, 1'b1, '{STAT_INSERTED, 16'sh0000, 16'h0000, 7'd2}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b1,
            '{STAT_EXTRACTED, 16'sh7FFF, 16'hFFFF, 7'd1}},
        '{OP_EXTRACT, 16'sh1234, 16'h5678, 1'b1,
            '{STAT_EXTRACTED, 16'sh8000, 16'h0000, 7'd0}},
        '{OP_EXTRACT, 16'sh7FFF, 16'hFFFF, 1'b1, '{STAT_EMPTY, 16'sh0000, 16'h0000, 7'd0}},
        '{OP_INSERT, 16'sh0005, 16'h00A1, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_INSERT, 16'sh0005, 16'h00A2, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_INSERT, 16'sh0005, 16'h00A3, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_INSERT, 16'shFFFF, 16'h00B1, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_INSERT, 16'sh0005, 16'h00A4, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_INSERT, 16'sh0000, 16'h00C1, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_INSERT, 16'sh7FFF, 16'h00D1, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_INSERT, 16'sh8000, 16'h00D2, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'shAAAA, 16'h5555, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'sh5555, 16'hAAAA, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b0, '{STAT_INSERTED, '0, '0, '0}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b1,
            '{STAT_EXTRACTED, 16'sh8000, 16'h00D2, 7'd0}},
        '{OP_EXTRACT, 16'sh0000, 16'h0000, 1'b1, '{STAT_EMPTY, 16'sh0000, 16'h0000, 7'd0}}
    };

    max_heap_priority_queue #(
        .CAPACITY (HEAP_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // hard limit on run length
    initial
    begin
        #80_000_000;
        $display("max_heap_priority_queue verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // move an entry down until neither child has a strictly larger priority
    function automatic void sift_down(input int pos, input int n);
        int                 l;
        int                 r;
        int                 big;
        logic signed [15:0] tp;
        logic [15:0]        tt;
        while (1'b1)
        begin
            l   = 2 * pos + 1;
            r   = l + 1;
            big = pos;
            if (l < n && heap_prio[big] < heap_prio[l])
                big = l;
            if (r < n && heap_prio[big] < heap_prio[r])
                big = r;
            if (big == pos)
                return;
            tp             = heap_prio[pos];
            tt             = heap_tag[pos];
            heap_prio[pos] = heap_prio[big];
            heap_tag[pos]  = heap_tag[big];
            heap_prio[big] = tp;
            heap_tag[big]  = tt;
            pos            = big;
        end
    endfunction

    // full bottom-up rebuild over the first n entries
    function automatic void rebuild_heap(input int n);
        if (n < 2)
            return;
        for (int i = (n - 1) / 2; i >= 0; i--)
            sift_down(i, n);
    endfunction

    // apply one request to the predicted heap and return its result
    function automatic heap_result_t apply_request(input logic op,
                                                   input logic signed [15:0] prio,
                                                   input logic [15:0] tag);
        heap_result_t res;
        int           last;
        res = '{STAT_INSERTED, '0, '0, '0};
        if (op == OP_INSERT)
        begin
            if (held >= HEAP_DEPTH)
                res.status = STAT_FULL;
            else
            begin
                heap_prio[held] = prio;
                heap_tag[held]  = tag;
                held++;
                rebuild_heap(held);
            end
        end
        else if (held == 0)
            res.status = STAT_EMPTY;
        else
        begin
            last            = held - 1;
            res.status      = STAT_EXTRACTED;
            res.prio        = heap_prio[0];
            res.tag         = heap_tag[0];
            heap_prio[0]    = heap_prio[last];
            heap_tag[0]     = heap_tag[last];
            heap_prio[last] = res.prio;
            heap_tag[last]  = res.tag;
            held            = last;
            rebuild_heap(held);
        end
        res.count = 7'(held);
        return res;
    endfunction

    // present one request and hold it until accepted
    task automatic send_req(input logic op, input logic signed [15:0] prio,
                            input logic [15:0] tag, input bit typed,
                            input heap_result_t want);
        @(negedge clk);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        pinned_q.push_back('{typed, want});
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tag, prio};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on every accepted request
    always @(posedge clk)
    begin
        pinned_result_t pin;
        heap_result_t   pred;
        if (rst_n && s_tvalid && s_tready)
        begin
            pred = apply_request(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
            if (pinned_q.size() == 0)
                expected_q.push_back(pred);
            else
            begin
                pin = pinned_q.pop_front();
                expected_q.push_back(pin.typed ? pin.want : pred);
            end
        end
    end

    // check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = expected_q.pop_front();
                if (m_tuser != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, want.status));
                if (m_tdata[15:0] != want.prio)
                    report_mismatch($sformatf("out_priority %0d, expected %0d",
                                              $signed(m_tdata[15:0]), want.prio));
                if (m_tdata[31:16] != want.tag)
                    report_mismatch($sformatf("out_payload %h, expected %h",
                                              m_tdata[31:16], want.tag));
                if (m_tdata[38:32] != want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              m_tdata[38:32], want.count));
            end
        end
    end

    // stimulus
    initial
    begin
        logic               rop;
        logic signed [15:0] rprio;
        logic [15:0]        rtag;
        int                 ins_pct;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < TABLE_LEN; i++)
            send_req(req_table[i].op, req_table[i].prio, req_table[i].tag,
                     req_table[i].typed, req_table[i].want);

        // random phases: fill past full, drain past empty, then mixed traffic
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 49; end
                default: begin send_gap_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                if (k < 90)
                    ins_pct = 95;
                else if (k < 180)
                    ins_pct = 5;
                else
                    ins_pct = 55;
                rop = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
                // narrow range forces ties, plus the extremes
                case ($urandom_range(9))
                    0, 1, 2, 3: rprio = 16'(int'($urandom_range(8)) - 4);
                    4:          rprio = 16'sh7FFF;
                    5:          rprio = 16'sh8000;
                    default:    rprio = 16'($urandom);
                endcase
                case ($urandom_range(7))
                    0:       rtag = 16'h0000;
                    1:       rtag = 16'hFFFF;
                    default: rtag = 16'($urandom);
                endcase
                send_req(rop, rprio, rtag, 1'b0, blank_result);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain outstanding results, then let the block settle
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (error_count == 0)
            $display("max_heap_priority_queue verification clean");
        else
            $display("max_heap_priority_queue verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_ctrl.sv
rtl/mhpq_dp.sv
rtl/max_heap_priority_queue.sv
test/max_heap_priority_queue_tb.sv
